@@ design/wsr_pkg.sv @@
// shared constants, types and codes of the symmetric wavetable reader
`default_nettype none

package wsr_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int INDEX_BITS  = 32;

	localparam int SAMPLE_W     = 16;
	localparam int FIELD_IDX_W  = 32;
	localparam int MODE_W       = 3;
	localparam int LEN_W        = 11;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 11;

	localparam int ADDR_W    = $clog2(TABLE_DEPTH);
	localparam int N_W       = ADDR_W + 1;
	localparam int POS_W     = ADDR_W + 3;
	localparam int CNT_W     = $clog2(INDEX_BITS);
	localparam int LEN_CMP_W = (LEN_W > N_W) ? LEN_W : N_W;
	localparam int IDX_CMP_W = (INDEX_BITS > N_W) ? INDEX_BITS : N_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE     = 3'd0,
		MODE_REPEAT   = 3'd1,
		MODE_MIRROR_X = 3'd2,
		MODE_MIRROR_Y = 3'd3,
		MODE_QUARTER  = 3'd4
	} mode_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPEAT_MODE  = 1'b0,
		CFG_TABLE_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FOLD,
		ST_READ
	} state_t;

endpackage

`default_nettype wire

@@ design/wsr_if.sv @@
// handshake channels of the wavetable reader: request, response and register write
`default_nettype none

interface wsr_req_if import wsr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [FIELD_IDX_W-1:0] sample_index;
	sample_t                write_sample;

	modport source (output valid, output command, output sample_index,
		output write_sample, input ready);
	modport sink (input valid, input command, input sample_index,
		input write_sample, output ready);
endinterface

interface wsr_rsp_if import wsr_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface wsr_cfg_if import wsr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/wavetable_symmetric_reader_top.sv @@
// Symmetric wavetable reader: a write item stores one signed sample in a
// 1024-entry table; a read item folds its phase index by the programmed
// length and repeat mode and returns one sample. A folded read passes
// through the bit-serial remainder unit (one index bit per cycle), takes
// over the remainder, folds it into a table address and reads the table,
// then loads the output register and returns to idle to accept the next
// item. Reads in mode none, with zero length or with an unknown mode skip
// the remainder unit. One item is worked on at a time; a finished result
// waits in the output register while the next item is accepted, and a read
// finding that register still full waits until it is taken. Registers must
// be written only while the block is idle; the block itself does not
// enforce this.
`default_nettype none

module wavetable_symmetric_reader_top import wsr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	wsr_req_if.sink  req,
	wsr_rsp_if.source rsp,
	wsr_cfg_if.sink  cfg
);

	state_t state_q, state_d;

	logic [MODE_W-1:0]     mode_q;
	logic [LEN_W-1:0]      len_q;
	logic [POS_W-1:0]      j_q;
	logic                  zero_q;
	logic                  neg_q;
	logic                  out_valid_q;
	sample_t               sample_q;

	logic [LEN_CMP_W-1:0]  len_c;
	logic [N_W-1:0]        n;
	logic [POS_W-1:0]      n1, n2, n3, n4;
	logic [POS_W-1:0]      period;
	logic [INDEX_BITS-1:0] idx;
	logic                  wr_in_range;
	logic                  rd_in_range;
	logic                  mode_ok;
	logic                  zero_d;
	logic                  skip_div;

	logic                  mod_start;
	logic                  mod_done;
	logic [POS_W-1:0]      mod_rem;

	logic                  ram_we;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [SAMPLE_W-1:0]   ram_rdata;
	logic [POS_W-1:0]      pos;
	logic                  neg_d;
	logic                  out_load;
	sample_t               rd_sample;

	// effective length and fold periods
	assign len_c = LEN_CMP_W'(len_q);
	assign n     = (len_c > LEN_CMP_W'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH) : N_W'(len_c);
	assign n1    = POS_W'(n);
	assign n2    = n1 << 1;
	assign n3    = n2 + n1;
	assign n4    = n1 << 2;

	always_comb begin
		case (mode_q)
			MODE_REPEAT:                 period = n1;
			MODE_MIRROR_X, MODE_MIRROR_Y: period = n2;
			default:                     period = n4;
		endcase
	end

	assign idx         = req.sample_index[INDEX_BITS-1:0];
	assign wr_in_range = IDX_CMP_W'(idx) < IDX_CMP_W'(TABLE_DEPTH);
	assign rd_in_range = IDX_CMP_W'(idx) < IDX_CMP_W'(n);
	assign mode_ok     = (mode_q == MODE_NONE) || (mode_q == MODE_REPEAT)
		|| (mode_q == MODE_MIRROR_X) || (mode_q == MODE_MIRROR_Y)
		|| (mode_q == MODE_QUARTER);
	assign zero_d      = (n == '0) || !mode_ok || ((mode_q == MODE_NONE) && !rd_in_range);
	assign skip_div    = zero_d || (mode_q == MODE_NONE);

	wsr_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (idx),
		.divisor   (period),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// fold the remainder into a table position
	always_comb begin
		pos   = j_q;
		neg_d = 1'b0;
		case (mode_q)
			MODE_MIRROR_X: begin
				if (j_q >= n1) begin
					pos = n2 - 1'b1 - j_q;
				end
			end
			MODE_MIRROR_Y: begin
				if (j_q >= n1) begin
					pos   = j_q - n1;
					neg_d = 1'b1;
				end
			end
			MODE_QUARTER: begin
				if (j_q < n1) begin
					pos = j_q;
				end else if (j_q < n2) begin
					pos = n2 - 1'b1 - j_q;
				end else if (j_q < n3) begin
					pos   = j_q - n2;
					neg_d = 1'b1;
				end else begin
					pos   = n4 - 1'b1 - j_q;
					neg_d = 1'b1;
				end
			end
			default: begin
				pos = j_q;
			end
		endcase
	end

	assign ram_raddr = pos[ADDR_W-1:0];

	wsr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx[ADDR_W-1:0]),
		.wdata (req.write_sample),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (zero_q) begin
			rd_sample = '0;
		end else if (!neg_q) begin
			rd_sample = sample_t'(ram_rdata);
		end else if (ram_rdata == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
			rd_sample = sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
		end else begin
			rd_sample = -sample_t'(ram_rdata);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == ST_IDLE);
		mod_start = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.command == CMD_WRITE) begin
						ram_we = wr_in_range;
					end else if (skip_div) begin
						state_d = ST_FOLD;
					end else begin
						mod_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (mod_done) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				ram_re  = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready && (req.command == CMD_READ)) begin
			j_q    <= POS_W'(idx);
			zero_q <= zero_d;
		end else if ((state_q == ST_DIV) && mod_done) begin
			j_q <= mod_rem;
		end
		if (ram_re) begin
			neg_q <= neg_d;
		end
		if (out_load) begin
			sample_q <= rd_sample;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.sample = sample_q;

	// registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			len_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_REPEAT_MODE:  mode_q <= cfg.data[MODE_W-1:0];
				CFG_TABLE_LENGTH: len_q  <= cfg.data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/wsr_ram.sv @@
// generic one-write one-read ram with registered read data
`default_nettype none

module wsr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/wsr_mod.sv @@
// bit-serial restoring remainder unit, one index bit per cycle
`default_nettype none

module wsr_mod import wsr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [INDEX_BITS-1:0] dividend,
	input  wire logic [POS_W-1:0]      divisor,
	output logic                       done,
	output logic      [POS_W-1:0]      remainder
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [INDEX_BITS-1:0] dvd_q;
	logic [POS_W-1:0]      rem_q;
	logic [POS_W:0]        trial;
	logic [POS_W:0]        trial_sub;
	logic [POS_W-1:0]      rem_d;

	assign trial     = {rem_q, dvd_q[INDEX_BITS-1]};
	assign trial_sub = trial - {1'b0, divisor};
	assign rem_d     = (trial >= {1'b0, divisor}) ? trial_sub[POS_W-1:0] : trial[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(INDEX_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[INDEX_BITS-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
